FILE: rtl/bur_pkg.sv
// Shared constants and types for the bounded undo/redo history unit.
package bur_pkg;

  localparam int DEPTH      = 64;
  localparam int TOKEN_BITS = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int LIMIT_W    = 7;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = ((2 * TOKEN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = TOKEN_BITS + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  typedef enum logic [KIND_W-1:0] {
    KIND_TRACK = 2'd0,
    KIND_UNDO  = 2'd1,
    KIND_REDO  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: rtl/bounded_undo_redo_history_unit.sv
// Bounded undo/redo history: one request in, one result out; each request runs
// accept, execute (a token memory read, plus a write on track) and publish from
// the registered read data, held while the output register is full, before the next
// is taken. A new request is accepted while the previous result still waits
// in the output register. The history limit may be written at any idle time and
// takes effect on the next request; the token memories need no clearing after reset.
module bounded_undo_redo_history_unit
  import bur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [KIND_W-1:0]     s_tuser,   // kind
  input  logic [IN_DATA_W-1:0]  s_tdata,   // redo_token, undo_token
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  m_tuser,   // ok
  output logic [OUT_DATA_W-1:0] m_tdata,   // token_out, undo_possible, redo_possible
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data   // history_limit
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  bur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bur_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_kind   (s_tuser),
    .in_data   (s_tdata),
    .cfg_wr    (cfg_valid),
    .cfg_limit (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ok    (m_tuser),
    .out_data  (m_tdata)
  );

endmodule

FILE: rtl/bur_ctrl.sv
// Request sequencer: accept, execute, then publish the result.
module bur_ctrl
  import bur_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  state_t state;

  always_comb begin
    s_tready    = (state == ST_IDLE);
    cmd.load    = (state == ST_IDLE) && s_tvalid;
    cmd.exec    = (state == ST_EXEC);
    cmd.publish = (state == ST_RESP) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/bur_dp.sv
// History datapath: ring pointers, token memories and the result register.
module bur_dp
  import bur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  cfg_wr,
  input  logic [LIMIT_W-1:0]    cfg_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic [TOKEN_BITS-1:0] undo_mem [DEPTH];
  logic [TOKEN_BITS-1:0] redo_mem [DEPTH];

  kind_t                 kind;
  logic [TOKEN_BITS-1:0] redo_in;
  logic [TOKEN_BITS-1:0] undo_in;
  logic [LIMIT_W-1:0]    history_limit;
  logic [PTR_W-1:0]      oldest;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      cursor;

  logic [PTR_W-1:0]      oldest_next;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      cursor_next;
  logic [CNT_W-1:0]      lim_eff;
  logic [CNT_W:0]        cur_inc;
  logic [CNT_W-1:0]      pos;
  logic [PTR_W-1:0]      slot;
  logic                  ok_next;
  logic                  wr_en;

  logic [TOKEN_BITS-1:0] rd_undo;
  logic [TOKEN_BITS-1:0] rd_redo;
  logic                  res_ok;
  logic                  res_undo_p;
  logic                  res_redo_p;
  kind_t                 res_kind;
  logic [TOKEN_BITS-1:0] tok_sel;
  logic [TOKEN_BITS-1:0] token_out;
  logic                  undo_possible;
  logic                  redo_possible;

  always_comb begin
    status.out_free = !out_valid || out_ready;
    lim_eff = (history_limit > LIMIT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(history_limit);
    cur_inc = {1'b0, cursor} + (CNT_W+1)'(1);
    pos     = (kind == KIND_UNDO) ? (cursor - CNT_W'(1)) : cursor;
    slot    = PTR_W'(CNT_W'(oldest) + pos);
    oldest_next = oldest;
    count_next  = count;
    cursor_next = cursor;
    ok_next     = 1'b1;
    wr_en       = 1'b0;
    case (kind)
      KIND_TRACK: begin
        wr_en = 1'b1;
        if (cur_inc > {1'b0, lim_eff}) begin
          oldest_next = oldest + PTR_W'(1);
          count_next  = cursor;
        end else begin
          count_next  = cur_inc[CNT_W-1:0];
          cursor_next = cur_inc[CNT_W-1:0];
        end
      end
      KIND_UNDO: begin
        if (cursor != '0) cursor_next = cursor - CNT_W'(1);
        else              ok_next = 1'b0;
      end
      KIND_REDO: begin
        if (cursor < count) cursor_next = cur_inc[CNT_W-1:0];
        else                ok_next = 1'b0;
      end
      default: begin
        count_next  = '0;
        cursor_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= kind_t'(in_kind);
      redo_in <= in_data[TOKEN_BITS-1:0];
      undo_in <= in_data[2*TOKEN_BITS-1:TOKEN_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        undo_mem[slot] <= undo_in;
        redo_mem[slot] <= redo_in;
      end
      rd_undo <= undo_mem[slot];
      rd_redo <= redo_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ok     <= ok_next;
      res_kind   <= kind;
      res_undo_p <= (cursor_next != '0);
      res_redo_p <= (cursor_next < count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_limit <= LIMIT_RESET;
      oldest        <= '0;
      count         <= '0;
      cursor        <= '0;
    end else begin
      if (cfg_wr) history_limit <= cfg_limit;
      if (cmd.exec) begin
        oldest <= oldest_next;
        count  <= count_next;
        cursor <= cursor_next;
      end
    end
  end

  always_comb begin
    if (!res_ok) begin
      tok_sel = '0;
    end else begin
      case (res_kind)
        KIND_UNDO: tok_sel = rd_undo;
        KIND_REDO: tok_sel = rd_redo;
        default:   tok_sel = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_ok        <= res_ok;
      token_out     <= tok_sel;
      undo_possible <= res_undo_p;
      redo_possible <= res_redo_p;
    end
  end

  assign out_data = {{(OUT_DATA_W-OUT_BITS){1'b0}}, redo_possible, undo_possible, token_out};

endmodule

FILE: test/bur_history_monitor.sv
`timescale 1ns / 1ps
// Channel monitor for the undo/redo history unit: predicts every result and compares it.
module bur_history_monitor
  import bur_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [KIND_W-1:0]     s_tuser,   // kind
  input  logic [IN_DATA_W-1:0]  s_tdata,   // redo_token, undo_token
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  m_tuser,   // ok
  input  logic [OUT_DATA_W-1:0] m_tdata,   // token_out, undo_possible, redo_possible
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data,  // history_limit
  output int                    mismatches,
  output int                    outstanding
);

  localparam int EXP_DEPTH = 8;

  typedef struct packed {
    logic                  ok;
    logic [TOKEN_BITS-1:0] token;
    logic                  undo_possible;
    logic                  redo_possible;
  } history_result_t;

  logic [TOKEN_BITS-1:0] undo_mem [DEPTH];
  logic [TOKEN_BITS-1:0] redo_mem [DEPTH];
  logic [PTR_W-1:0]      oldest_ptr;
  logic [CNT_W-1:0]      entry_total;
  logic [CNT_W-1:0]      hist_cursor;
  logic [LIMIT_W-1:0]    limit_reg;
  history_result_t       expected_fifo [EXP_DEPTH];
  logic [2:0]            exp_head;
  logic [2:0]            exp_tail;
  int                    exp_level;

  function automatic history_result_t apply_history_op(kind_t op,
                                                       logic [TOKEN_BITS-1:0] redo_tok,
                                                       logic [TOKEN_BITS-1:0] undo_tok);
    history_result_t  res;
    logic [CNT_W-1:0] lim;
    logic [PTR_W-1:0] slot;
    res    = '0;
    res.ok = 1'b1;
    lim    = (limit_reg > LIMIT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(limit_reg);
    case (op)
      KIND_TRACK: begin
        entry_total    = hist_cursor;
        slot           = oldest_ptr + PTR_W'(hist_cursor);
        redo_mem[slot] = redo_tok;
        undo_mem[slot] = undo_tok;
        entry_total    = entry_total + CNT_W'(1);
        hist_cursor    = hist_cursor + CNT_W'(1);
        if (hist_cursor > lim) begin
          oldest_ptr  = oldest_ptr + PTR_W'(1);
          entry_total = entry_total - CNT_W'(1);
          hist_cursor = hist_cursor - CNT_W'(1);
        end
      end
      KIND_UNDO: begin
        if (hist_cursor != '0) begin
          hist_cursor = hist_cursor - CNT_W'(1);
          slot        = oldest_ptr + PTR_W'(hist_cursor);
          res.token   = undo_mem[slot];
        end else begin
          res.ok = 1'b0;
        end
      end
      KIND_REDO: begin
        if (hist_cursor < entry_total) begin
          slot        = oldest_ptr + PTR_W'(hist_cursor);
          res.token   = redo_mem[slot];
          hist_cursor = hist_cursor + CNT_W'(1);
        end else begin
          res.ok = 1'b0;
        end
      end
      default: begin
        entry_total = '0;
        hist_cursor = '0;
      end
    endcase
    res.undo_possible = (hist_cursor != '0);
    res.redo_possible = (hist_cursor < entry_total);
    return res;
  endfunction

  always @(posedge clk) begin
    history_result_t got;
    history_result_t want;
    if (rst) begin
      oldest_ptr  = '0;
      entry_total = '0;
      hist_cursor = '0;
      limit_reg   = LIMIT_RESET;
      exp_head    = '0;
      exp_tail    = '0;
      exp_level   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_reg = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got.ok            = m_tuser;
        got.token         = m_tdata[TOKEN_BITS-1:0];
        got.undo_possible = m_tdata[TOKEN_BITS];
        got.redo_possible = m_tdata[TOKEN_BITS+1];
        if (exp_level == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result ok=%0b token=%h undo=%0b redo=%0b", $time,
                     got.ok, got.token, got.undo_possible, got.redo_possible);
          end
        end else begin
          want      = expected_fifo[exp_head];
          exp_head  = exp_head + 3'd1;
          exp_level = exp_level - 1;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected ok=%0b token=%h undo=%0b redo=%0b", $time,
                       want.ok, want.token, want.undo_possible, want.redo_possible);
              $display("%0t:          actual   ok=%0b token=%h undo=%0b redo=%0b", $time,
                       got.ok, got.token, got.undo_possible, got.redo_possible);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_history_op(kind_t'(s_tuser), s_tdata[TOKEN_BITS-1:0],
                                s_tdata[2*TOKEN_BITS-1:TOKEN_BITS]);
        if (exp_level == EXP_DEPTH) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: too many requests in flight", $time);
          end
        end else begin
          expected_fifo[exp_tail] = want;
          exp_tail  = exp_tail + 3'd1;
          exp_level = exp_level + 1;
        end
      end
    end
    outstanding <= exp_level;
  end

endmodule

FILE: test/tb_bounded_undo_redo_history_unit.sv
`timescale 1ns / 1ps
// Top-level testbench for the undo/redo history unit: stimulus, flow control and verdict.
module tb_bounded_undo_redo_history_unit;
  import bur_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [KIND_W-1:0]     s_tuser   = '0;   // kind
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // redo_token, undo_token
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  m_tuser;          // ok
  logic [OUT_DATA_W-1:0] m_tdata;          // token_out, undo_possible, redo_possible
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LIMIT_W-1:0]    cfg_data  = '0;   // history_limit

  int mismatches;
  int outstanding;
  int sent_count   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit idle_enabled = 1'b1;
  bit hold_request = 1'b0;
  bit hold_taken   = 1'b0;

  always #6 clk = ~clk;

  bounded_undo_redo_history_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bur_history_monitor u_history_monitor (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tuser     (m_tuser),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= !idle_enabled || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_bounded_undo_redo_history_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(kind_t op, logic [TOKEN_BITS-1:0] redo_tok,
                              logic [TOKEN_BITS-1:0] undo_tok);
    while (idle_enabled && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {undo_tok, redo_tok};
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (results_seen != sent_count) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int lim, int count, int track_pct, int undo_pct, int redo_pct);
    int    pick;
    kind_t op;
    if (lim >= 0) begin
      write_limit(LIMIT_W'(lim));
    end
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < track_pct) op = KIND_TRACK;
      else if (pick < track_pct + undo_pct) op = KIND_UNDO;
      else if (pick < track_pct + undo_pct + redo_pct) op = KIND_REDO;
      else op = KIND_CLEAR;
      send_request(op, $urandom(), $urandom());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_REDO, '0, '0);
    send_request(KIND_TRACK, '1, '1);
    send_request(KIND_TRACK, '0, '0);
    send_request(KIND_TRACK, 32'ha5a5a5a5, 32'h5a5a5a5a);
    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_REDO, '0, '0);
    send_request(KIND_REDO, '0, '0);
    send_request(KIND_REDO, '0, '0);
    send_request(KIND_UNDO, '1, '1);
    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_TRACK, 32'h12345678, 32'h87654321);
    send_request(KIND_REDO, '0, '0);
    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_CLEAR, '1, '1);
    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_REDO, '0, '0);
    write_limit(LIMIT_W'(0));
    send_request(KIND_TRACK, 32'hdeadbeef, 32'hcafef00d);
    send_request(KIND_UNDO, '0, '0);
    send_request(KIND_REDO, '0, '0);
    write_limit(LIMIT_W'(2));
    repeat (3) send_request(KIND_TRACK, $urandom(), $urandom());
    repeat (3) send_request(KIND_UNDO, '0, '0);

    run_phase(64, 50, 60, 20, 18);
    run_phase(5, 40, 40, 30, 25);
    idle_enabled = 1'b0;
    run_phase(127, 90, 85, 8, 7);
    idle_enabled = 1'b1;
    hold_request = 1'b1;
    run_phase(-1, 80, 10, 55, 33);
    run_phase(1, 40, 40, 30, 25);
    run_phase(64, 50, 50, 25, 20);
    run_phase($urandom_range(127), 40, 45, 25, 25);
    run_phase(0, 20, 40, 30, 25);
    run_phase(33, 40, 50, 25, 20);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_bounded_undo_redo_history_unit: PASS");
    end else begin
      $display("tb_bounded_undo_redo_history_unit: FAIL");
    end
    $finish;
  end

endmodule
